### design/bivariate_polynomial_multiplier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bivariate polynomial multiplier
// Immediate-implication and next-cycle checks, clocked on clk and
// disabled while rst_n is low. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BIVARIATE_POLYNOMIAL_MULTIPLIER_MACROS_SVH
`define BIVARIATE_POLYNOMIAL_MULTIPLIER_MACROS_SVH

`ifndef SYNTHESIS
// label: antecedent implies consequent in the same cycle
`define BPM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpm check failed");
// label: antecedent implies consequent in the next cycle
`define BPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpm check failed");
`else
`define BPM_ASSERT(lbl, ante, cons)
`define BPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Types, codes and sizing for the bivariate polynomial multiplier.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int MAX_TERMS    = 8;
  localparam int MAX_EXPONENT = 15;
  localparam int COEF_BITS    = 16;

  // Fixed field widths of the request and result items
  localparam int IN_COEF_W  = 16;
  localparam int IN_EXP_W   = 4;
  localparam int OUT_COEF_W = 40;
  localparam int PEXP_W     = 5;

  // Stored coefficients never exceed the 16-bit input field
  localparam int TERM_CW = (COEF_BITS < IN_COEF_W) ? COEF_BITS : IN_COEF_W;
  localparam int COEF_MAX = (1 << (TERM_CW - 1)) - 1;
  localparam int COEF_MIN = -COEF_MAX - 1;
  localparam int PROD_W   = 2 * TERM_CW;
  // At most 64 products of 16-bit values: sums stay within 38 bits
  localparam int ACC_W    = OUT_COEF_W;

  localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);

  localparam int GRID_XW    = PEXP_W;
  localparam int GRID_AW    = 2 * GRID_XW;
  localparam int GRID_SIDE  = 1 << GRID_XW;
  localparam int GRID_DEPTH = 1 << GRID_AW;

  localparam logic [1:0] OP_LEFT  = 2'd0;
  localparam logic [1:0] OP_RIGHT = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_SCAN,
    ST_FIN
  } bpm_state_t;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [IN_COEF_W-1:0] coefficient;
    logic [IN_EXP_W-1:0]         x_power;
    logic [IN_EXP_W-1:0]         y_power;
  } bpm_in_t;

  typedef struct packed {
    logic signed [OUT_COEF_W-1:0] product_coefficient;
    logic [PEXP_W-1:0]            product_x_power;
    logic [PEXP_W-1:0]            product_y_power;
    logic                         last_term;
    logic                         empty_product;
    logic                         terms_dropped;
  } bpm_out_t;

  typedef struct packed {
    logic signed [TERM_CW-1:0] coef;
    logic [IN_EXP_W-1:0]       xp;
    logic [IN_EXP_W-1:0]       yp;
  } bpm_term_t;

  localparam int TERM_W = $bits(bpm_term_t);

  // Grid word returned by a scan read, with its coordinates
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] coef;
    logic [GRID_XW-1:0]      x;
    logic [GRID_XW-1:0]      y;
  } bpm_scan_t;

  typedef struct packed {
    logic slot_free;
    logic fin_ack;
  } bpm_emit_st_t;

  function automatic logic signed [TERM_CW-1:0] sat_coef(
    input logic signed [IN_COEF_W-1:0] c
  );
    if (int'(c) > COEF_MAX) return TERM_CW'(COEF_MAX);
    if (int'(c) < COEF_MIN) return TERM_CW'(COEF_MIN);
    return TERM_CW'(c);
  endfunction

  function automatic logic [IN_EXP_W-1:0] sat_exp(input logic [IN_EXP_W-1:0] e);
    if (int'(e) > MAX_EXPONENT) return IN_EXP_W'(MAX_EXPONENT);
    return e;
  endfunction

endpackage

### design/bpm_ram.sv
// ----------------------------------------------------------------------------
// bpm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bpm_emit.sv
// ----------------------------------------------------------------------------
// bpm_emit
// Result stage: holds the latest nonzero grid word back by one so that the
// final term can be marked, and drives the output register.
// ----------------------------------------------------------------------------
module bpm_emit
  import bpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bpm_scan_t    scan,
  input  logic         fin_req,
  input  logic         dropped,
  input  logic         out_stall,
  output logic         out_valid,
  output bpm_out_t     out_data,
  output bpm_emit_st_t emit_st
);

  logic                    out_vld_r, out_vld_nxt;
  bpm_out_t                out_r;
  logic                    hold_vld_r, hold_vld_nxt;
  logic signed [ACC_W-1:0] hold_coef_r;
  logic [GRID_XW-1:0]      hold_x_r;
  logic [GRID_XW-1:0]      hold_y_r;

  logic     hit;
  logic     out_free;
  logic     load;
  logic     fin_ack;
  bpm_out_t load_data;

  assign hit      = scan.vld && (scan.coef != '0);
  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    load         = 1'b0;
    fin_ack      = 1'b0;
    hold_vld_nxt = hold_vld_r;
    load_data    = '0;
    load_data.product_coefficient = OUT_COEF_W'(hold_coef_r);
    load_data.product_x_power     = hold_x_r;
    load_data.product_y_power     = hold_y_r;
    load_data.terms_dropped       = dropped;
    if (hit) begin
      // a new term pushes the held one out; the slot is free by construction
      load         = hold_vld_r;
      hold_vld_nxt = 1'b1;
    end else if (fin_req && out_free) begin
      fin_ack      = 1'b1;
      load         = 1'b1;
      hold_vld_nxt = 1'b0;
      load_data.last_term = 1'b1;
      if (!hold_vld_r) begin
        load_data.product_coefficient = '0;
        load_data.product_x_power     = '0;
        load_data.product_y_power     = '0;
        load_data.empty_product       = 1'b1;
      end
    end
    out_vld_nxt = load || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= load_data;
    end
    if (hit) begin
      hold_coef_r <= scan.coef;
      hold_x_r    <= scan.x;
      hold_y_r    <= scan.y;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_data          = out_r;
  assign emit_st.slot_free = !out_vld_nxt;
  assign emit_st.fin_ack   = fin_ack;

endmodule

### design/bivariate_polynomial_multiplier.sv
// ----------------------------------------------------------------------------
// bivariate_polynomial_multiplier
// Loads left and right operand terms, accumulates all pair products into a
// 32 x 32 grid held in RAM, then scans the grid and emits nonzero terms.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall   | bpm_in_t
//   out_    | result    | out_valid/out_stall | bpm_out_t
//
// After reset the grid RAM is cleared; no request is taken until then. A
// multiply of L by R terms runs all L*R pairs through the read-add-write
// pipeline on the grid RAM, then scans the grid, skipping each untouched x
// row and reading every entry of a touched x row, and closes by marking the
// last term. Scan reads clear the grid behind them.
// out_stall holds the scan; the result register lets the next multiply start
// while the final result still waits.
// ----------------------------------------------------------------------------
`include "bivariate_polynomial_multiplier_macros.svh"

module bivariate_polynomial_multiplier
  import bpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bpm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bpm_out_t out_data
);

  bpm_state_t state_r, state_nxt;

  logic [GRID_AW-1:0] clr_cnt_r;
  logic [CNT_W-1:0]   lcnt_r, rcnt_r;
  logic               ovf_r;
  logic [TERM_AW-1:0] pi_r, pj_r;

  logic                     s1_vld_r;
  logic                     s2_vld_r;
  logic [GRID_AW-1:0]       s2_addr_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                     wr_vld_r;
  logic [GRID_AW-1:0]       wr_addr_r;
  logic signed [ACC_W-1:0]  wr_data_r;

  logic [GRID_SIDE-1:0] row_r;
  logic [GRID_XW-1:0]   sx_r, sy_r;
  logic                 rd_vld_r;
  logic [GRID_XW-1:0]   rd_x_r, rd_y_r;

  // request decode
  logic                      in_acc;
  logic signed [TERM_CW-1:0] ld_coef;
  bpm_term_t                 ld_term;
  logic                      ld_live;
  logic                      l_full, r_full;
  logic                      l_we, r_we;

  // operand and accumulate path
  logic [TERM_W-1:0]        l_rdata, r_rdata;
  bpm_term_t                l_term, r_term;
  logic [GRID_XW-1:0]       s1_px, s1_py;
  logic [GRID_AW-1:0]       s1_addr;
  logic signed [PROD_W-1:0] s1_prod;
  logic [ACC_W-1:0]         g_rdata;
  logic signed [ACC_W-1:0]  acc_base, acc_sum;
  logic                     pair_j_last, pair_last;

  // grid port
  logic               g_we;
  logic [GRID_AW-1:0] g_waddr, g_raddr;
  logic [ACC_W-1:0]   g_wdata;

  // scan
  logic         row_hit;
  logic         scan_issue, scan_skip, scan_last;
  logic         fin_req;
  bpm_scan_t    scan;
  bpm_emit_st_t emit_st;

  assign in_acc  = in_valid && !in_stall;
  assign ld_coef = sat_coef(in_data.coefficient);
  assign ld_live = (ld_coef != '0);
  assign l_full  = (lcnt_r >= CNT_W'(MAX_TERMS));
  assign r_full  = (rcnt_r >= CNT_W'(MAX_TERMS));
  assign l_we    = in_acc && (in_data.opcode == OP_LEFT) && ld_live && !l_full;
  assign r_we    = in_acc && (in_data.opcode == OP_RIGHT) && ld_live && !r_full;

  always_comb begin
    ld_term.coef = ld_coef;
    ld_term.xp   = sat_exp(in_data.x_power);
    ld_term.yp   = sat_exp(in_data.y_power);
  end

  bpm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (lcnt_r[TERM_AW-1:0]),
    .wdata (ld_term),
    .raddr (pi_r),
    .rdata (l_rdata)
  );

  bpm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rcnt_r[TERM_AW-1:0]),
    .wdata (ld_term),
    .raddr (pj_r),
    .rdata (r_rdata)
  );

  bpm_ram #(.WIDTH(ACC_W), .DEPTH(GRID_DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // stage 1: operand words are out; form product and grid address
  assign l_term  = bpm_term_t'(l_rdata);
  assign r_term  = bpm_term_t'(r_rdata);
  assign s1_px   = GRID_XW'(l_term.xp) + GRID_XW'(r_term.xp);
  assign s1_py   = GRID_XW'(l_term.yp) + GRID_XW'(r_term.yp);
  assign s1_addr = {s1_px, s1_py};
  assign s1_prod = l_term.coef * r_term.coef;

  // stage 2: grid word is out; take the word written last cycle if it matches
  assign acc_base = (wr_vld_r && (wr_addr_r == s2_addr_r)) ? wr_data_r
                                                           : signed'(g_rdata);
  assign acc_sum  = acc_base + ACC_W'(s2_prod_r);

  assign pair_j_last = (CNT_W'(pj_r) == rcnt_r - CNT_W'(1));
  assign pair_last   = pair_j_last && (CNT_W'(pi_r) == lcnt_r - CNT_W'(1));

  assign row_hit    = row_r[sx_r];
  assign scan_last  = (sx_r == '0) && (scan_skip || (scan_issue && (sy_r == '1)));
  assign fin_req    = (state_r == ST_FIN) && !rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == GRID_AW'(GRID_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (in_data.opcode == OP_MUL)) begin
          if ((lcnt_r == '0) || (rcnt_r == '0)) state_nxt = ST_SCAN;
          else state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (pair_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (emit_st.fin_ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs and grid port selection
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    scan_issue = 1'b0;
    scan_skip  = 1'b0;
    g_we       = 1'b0;
    g_waddr    = s2_addr_r;
    g_wdata    = acc_sum;
    g_raddr    = s1_addr;
    case (state_r)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_cnt_r;
        g_wdata = '0;
      end
      ST_MUL, ST_DRAIN: begin
        g_we = s2_vld_r;
      end
      ST_SCAN: begin
        scan_skip  = !row_hit;
        scan_issue = row_hit && emit_st.slot_free;
        // read and zero the same entry: the read returns the old sum
        g_raddr    = {sx_r, sy_r};
        g_waddr    = {sx_r, sy_r};
        g_wdata    = '0;
        g_we       = scan_issue;
      end
      default: begin
        g_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      lcnt_r    <= '0;
      rcnt_r    <= '0;
      ovf_r     <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      wr_vld_r  <= 1'b0;
      rd_vld_r  <= 1'b0;
      row_r     <= '0;
      pi_r      <= '0;
      pj_r      <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= (state_r == ST_MUL);
      s2_vld_r <= s1_vld_r;
      wr_vld_r <= s2_vld_r;
      rd_vld_r <= scan_issue;

      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + GRID_AW'(1);

      if (l_we) lcnt_r <= lcnt_r + CNT_W'(1);
      if (r_we) rcnt_r <= rcnt_r + CNT_W'(1);
      if (in_acc && ld_live && (((in_data.opcode == OP_LEFT) && l_full) ||
                                ((in_data.opcode == OP_RIGHT) && r_full))) begin
        ovf_r <= 1'b1;
      end

      if (in_acc && (in_data.opcode == OP_MUL)) begin
        pi_r <= '0;
        pj_r <= '0;
        sx_r <= '1;
        sy_r <= '0;
      end

      // advance the pair walk, right operand fastest
      if (state_r == ST_MUL) begin
        if (pair_j_last) begin
          pj_r <= '0;
          pi_r <= pi_r + TERM_AW'(1);
        end else begin
          pj_r <= pj_r + TERM_AW'(1);
        end
      end

      if (s1_vld_r) row_r[s1_px] <= 1'b1;

      if (scan_skip) begin
        sx_r <= sx_r - GRID_XW'(1);
      end else if (scan_issue) begin
        sy_r <= sy_r + GRID_XW'(1);
        if (sy_r == '1) sx_r <= sx_r - GRID_XW'(1);
      end

      // drop operands, flag and row marks once the last result is queued
      if (emit_st.fin_ack) begin
        lcnt_r <= '0;
        rcnt_r <= '0;
        ovf_r  <= 1'b0;
        row_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= s1_addr;
    s2_prod_r <= s1_prod;
    wr_addr_r <= s2_addr_r;
    wr_data_r <= acc_sum;
    rd_x_r    <= sx_r;
    rd_y_r    <= sy_r;
  end

  always_comb begin
    scan.vld  = rd_vld_r;
    scan.coef = signed'(g_rdata);
    scan.x    = rd_x_r;
    scan.y    = rd_y_r;
  end

  bpm_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan),
    .fin_req   (fin_req),
    .dropped   (ovf_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .emit_st   (emit_st)
  );

  `BPM_ASSERT(a_rows_clear_idle, state_r == ST_IDLE, row_r == '0)
  `BPM_ASSERT(a_scan_read_slot_free, rd_vld_r, !out_valid)
  `BPM_ASSERT(a_acc_write_in_mul, s2_vld_r, (state_r == ST_MUL) || (state_r == ST_DRAIN))

endmodule

### test/bpm_checker.sv
// ----------------------------------------------------------------------------
// bpm_checker
// Watches the request and result channels of the polynomial multiplier. It
// keeps its own copy of both operands, forms the expected product terms when
// a multiply request is taken and compares every result against them.
// ----------------------------------------------------------------------------
module bpm_checker
  import bpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  bpm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  bpm_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       product_count,
  output int       term_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COEF_HI = (longint'(1) <<< (COEF_BITS - 1)) - 1;
  localparam longint COEF_LO = -COEF_HI - 1;
  localparam longint SUM_HI  = (longint'(1) <<< (OUT_COEF_W - 1)) - 1;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam int     SIDE    = 1 << PEXP_W;
  localparam int     MAX_OUT = 64;

  typedef struct {
    longint coef;
    int     xp;
    int     yp;
  } operand_term_t;

  operand_term_t left_ops[MAX_TERMS];
  operand_term_t right_ops[MAX_TERMS];
  int            left_fill    = 0;
  int            right_fill   = 0;
  bit            capacity_hit = 1'b0;
  bpm_out_t      expected_terms[$];
  int            errors   = 0;
  int            products = 0;
  int            terms    = 0;

  function automatic longint clamp_coef(input logic signed [IN_COEF_W-1:0] raw);
    longint v;
    v = longint'(raw);
    if (v > COEF_HI) v = COEF_HI;
    if (v < COEF_LO) v = COEF_LO;
    return v;
  endfunction

  function automatic int clamp_exp(input logic [IN_EXP_W-1:0] raw);
    return (int'(raw) > MAX_EXPONENT) ? MAX_EXPONENT : int'(raw);
  endfunction

  task automatic load_term(input bit to_left, input bpm_in_t req);
    operand_term_t t;
    t.coef = clamp_coef(req.coefficient);
    t.xp   = clamp_exp(req.x_power);
    t.yp   = clamp_exp(req.y_power);
    // zero terms neither take a slot nor count as overflow
    if (t.coef != 0) begin
      if (to_left) begin
        if (left_fill >= MAX_TERMS) begin
          capacity_hit = 1'b1;
        end else begin
          left_ops[left_fill] = t;
          left_fill++;
        end
      end else begin
        if (right_fill >= MAX_TERMS) begin
          capacity_hit = 1'b1;
        end else begin
          right_ops[right_fill] = t;
          right_fill++;
        end
      end
    end
  endtask

  task automatic predict_product();
    longint   grid [SIDE][SIDE];
    longint   s;
    bpm_out_t r;
    bpm_out_t prev;
    bit       have_prev;
    int       n;
    have_prev = 1'b0;
    n = 0;
    for (int x = 0; x < SIDE; x++)
      for (int y = 0; y < SIDE; y++)
        grid[x][y] = 0;
    for (int i = 0; i < left_fill; i++)
      for (int j = 0; j < right_fill; j++)
        grid[(left_ops[i].xp + right_ops[j].xp) % SIDE]
            [(left_ops[i].yp + right_ops[j].yp) % SIDE] +=
          left_ops[i].coef * right_ops[j].coef;
    // scan x descending, y ascending; hold each term back to mark the last one
    for (int x = SIDE - 1; x >= 0; x--) begin
      for (int y = 0; y < SIDE; y++) begin
        s = grid[x][y];
        if (s != 0 && n < MAX_OUT) begin
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          r = '0;
          r.product_coefficient = s[OUT_COEF_W-1:0];
          r.product_x_power     = PEXP_W'(x);
          r.product_y_power     = PEXP_W'(y);
          r.terms_dropped       = capacity_hit;
          if (have_prev) expected_terms.insert(expected_terms.size(), prev);
          prev = r;
          have_prev = 1'b1;
          n++;
        end
      end
    end
    if (have_prev) begin
      prev.last_term = 1'b1;
      expected_terms.insert(expected_terms.size(), prev);
    end else begin
      r = '0;
      r.last_term     = 1'b1;
      r.empty_product = 1'b1;
      r.terms_dropped = capacity_hit;
      expected_terms.insert(expected_terms.size(), r);
    end
    left_fill    = 0;
    right_fill   = 0;
    capacity_hit = 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bpm_out_t want;
    if (!rst_n) begin
      left_fill    = 0;
      right_fill   = 0;
      capacity_hit = 1'b0;
      expected_terms.delete();
    end else begin
      if (out_valid && !out_stall) begin
        terms++;
        if (expected_terms.size() == 0) begin
          $error("unexpected result term: coefficient %0d at x^%0d y^%0d",
                 out_data.product_coefficient, out_data.product_x_power,
                 out_data.product_y_power);
          errors++;
        end else begin
          want = expected_terms.pop_front();
          check_field("product_coefficient", want.product_coefficient,
                      out_data.product_coefficient);
          check_field("product_x_power", want.product_x_power, out_data.product_x_power);
          check_field("product_y_power", want.product_y_power, out_data.product_y_power);
          check_field("last_term", want.last_term, out_data.last_term);
          check_field("empty_product", want.empty_product, out_data.empty_product);
          check_field("terms_dropped", want.terms_dropped, out_data.terms_dropped);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          OP_LEFT:  load_term(1'b1, in_data);
          OP_RIGHT: load_term(1'b0, in_data);
          OP_MUL: begin
            predict_product();
            products++;
          end
          default: ;
        endcase
      end
    end
    fail_count    <= errors;
    pending       <= expected_terms.size();
    product_count <= products;
    term_count    <= terms;
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the bivariate polynomial multiplier. A directed part covers
// empty operands, coefficient and exponent extremes, ignored and cancelling
// terms, overflow of an operand and a full 64-term product; random load and
// multiply sequences follow under four pacing phases. A checker module
// predicts and compares every result term.
// ----------------------------------------------------------------------------
module tb
  import bpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int LIMIT_NS      = 20_000_000;
  localparam int SETTLE_CYCLES = 2100;
  localparam int PHASE_ITEMS   = 62;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  bpm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bpm_out_t out_data;

  int fail_count, pending, product_count, term_count;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;

  bivariate_polynomial_multiplier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  bpm_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .product_count(product_count),
    .term_count   (term_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic bpm_in_t req_of(input logic [1:0] op, input int c,
                                     input int x, input int y);
    bpm_in_t t;
    t.opcode      = op;
    t.coefficient = IN_COEF_W'(c);
    t.x_power     = IN_EXP_W'(x);
    t.y_power     = IN_EXP_W'(y);
    return t;
  endfunction

  function automatic bpm_in_t make_term(input logic [1:0] op);
    bpm_in_t t;
    t.opcode = op;
    case ($urandom_range(0, 7))
      0:       t.coefficient = IN_COEF_W'($urandom_range(0, 6) - 3);
      1:       t.coefficient = 16'h7FFF;
      2:       t.coefficient = 16'h8000;
      default: t.coefficient = IN_COEF_W'($urandom);
    endcase
    // low exponents often, so that like terms collide
    t.x_power = IN_EXP_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    t.y_power = IN_EXP_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
    return t;
  endfunction

  function automatic int pick_size();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
  endfunction

  task automatic send_request(input bpm_in_t req);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (req.opcode != OP_NONE && (req.opcode == OP_MUL || req.coefficient != 0)) sent++;
  endtask

  task automatic run_product(input int nl, input int nr);
    int l;
    int r;
    l = nl;
    r = nr;
    while (l + r > 0) begin
      if (r == 0 || (l > 0 && $urandom_range(0, 1) == 1)) begin
        send_request(make_term(OP_LEFT));
        l--;
      end else begin
        send_request(make_term(OP_RIGHT));
        r--;
      end
    end
    send_request(make_term(OP_MUL));
  endtask

  task automatic run_phase(input int idle, input int stall);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = sent;
    while (sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_request(make_term(2'($urandom_range(0, 3))));
      else run_product(pick_size(), pick_size());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // multiply with nothing loaded
    send_request(req_of(OP_MUL, 0, 0, 0));

    // coefficient and exponent extremes
    send_request(req_of(OP_LEFT, 32767, 15, 15));
    send_request(req_of(OP_LEFT, -32768, 0, 0));
    send_request(req_of(OP_RIGHT, -32768, 15, 15));
    send_request(req_of(OP_MUL, 0, 0, 0));

    // zero load and unused opcode are ignored; the pair products cancel
    send_request(req_of(OP_LEFT, 5, 1, 0));
    send_request(req_of(OP_LEFT, 0, 3, 3));
    send_request(req_of(OP_NONE, 123, 4, 4));
    send_request(req_of(OP_RIGHT, 3, 2, 2));
    send_request(req_of(OP_RIGHT, -3, 2, 2));
    send_request(req_of(OP_MUL, 0, 0, 0));

    // full operands, one extra term dropped, 64 distinct product terms
    for (int i = 0; i < MAX_TERMS; i++)
      send_request(req_of(OP_LEFT, (i % 2 == 1) ? -(4096 + i) : 4096 + i, i, 0));
    send_request(req_of(OP_LEFT, 0, 1, 1));
    send_request(req_of(OP_LEFT, 77, 2, 2));
    for (int j = 0; j < MAX_TERMS; j++)
      send_request(req_of(OP_RIGHT, 100 * j - 350, 0, j));
    send_request(req_of(OP_MUL, 0, 0, 0));

    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(23, 23);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d expected result terms still outstanding", pending);
    $display("Covered %0d requests over four pacing phases: %0d products, %0d result terms",
             sent, product_count, term_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
